// ===== hw/rtl/spod_pkg.sv =====
// Shared types and constants of the shape pair overlap detector.
package spod_pkg;

  localparam int SLOT_W      = 6;
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 15;
  localparam int FRAC_BITS   = 4;
  localparam int SQ_W        = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_RECT   = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  typedef enum logic [1:0] {
    TEST_RR = 2'd0,
    TEST_CC = 2'd1,
    TEST_RC = 2'd2
  } test_t;

  typedef struct packed {
    logic [SLOT_W-1:0]         pair_slot;
    logic                      new_pair;
    logic                      kind_a;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic [SIZE_W-1:0]         a_w;
    logic [SIZE_W-1:0]         a_h;
    logic                      kind_b;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic [SIZE_W-1:0]         b_w;
    logic [SIZE_W-1:0]         b_h;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              overlapping;
    logic              collision_started;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              fresh;
    logic              ov;
  } result_t;

endpackage

// ===== hw/rtl/spod_if.sv =====
// Valid/ready channel interfaces for pair items and result items.
interface spod_pair_if ();
  logic                 valid;
  logic                 ready;
  spod_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spod_result_if ();
  logic                 valid;
  logic                 ready;
  spod_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spod_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spod_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/spod_front.sv =====
// Front pipeline: accept pair items and decide overlap in four stages.
module spod_front (
  input  logic              clk,
  input  logic              rst,
  spod_pair_if.sink         pairs,
  input  logic              clr_busy,
  output logic              q_push,
  output spod_pkg::result_t q_data,
  input  logic              q_full
);

  localparam logic signed [17:0] ONE = 18'(1 << spod_pkg::FRAC_BITS);

  spod_pkg::in_item_t d;
  logic en;
  logic accept;

  // stage 1 inputs
  logic signed [17:0] ax_e, ay_e, bx_e, by_e;
  logic signed [17:0] a_xr, a_yb, b_xr, b_yb;
  logic               rr_ov;
  logic               rect_a;
  logic signed [18:0] rx19, ry19, cx19, cy19, rw19, rh19;
  logic [spod_pkg::SIZE_W-1:0] rw_sel, rh_sel, r_sel;
  spod_pkg::test_t    test_c;

  // stage 1 registers
  logic                      v1;
  logic [spod_pkg::SLOT_W-1:0] s1_slot;
  logic                      s1_fresh;
  spod_pkg::test_t           s1_test;
  logic                      s1_rr;
  logic signed [16:0]        s1_dx, s1_dy;
  logic [15:0]               s1_rs;
  logic signed [18:0]        s1_ddx, s1_ddy;
  logic [spod_pkg::SIZE_W-1:0] s1_rw, s1_rh;
  logic [15:0]               s1_r2;

  // stage 2 logic
  logic signed [16:0] abs_dx, abs_dy;
  logic signed [18:0] abs_ddx, abs_ddy;
  logic [17:0]        adx, ady;
  logic [16:0]        lim_x, lim_y;
  logic               far, near;
  logic [spod_pkg::SQ_W-1:0] ex, ey;
  logic               dec_c, val_c;
  logic [spod_pkg::SQ_W-1:0] p_c, q_c, s_c;

  // stage 2 registers
  logic                      v2;
  logic [spod_pkg::SLOT_W-1:0] s2_slot;
  logic                      s2_fresh, s2_dec, s2_val;
  logic [spod_pkg::SQ_W-1:0] s2_p, s2_q, s2_s;

  // stage 3 registers
  logic                      v3;
  logic [spod_pkg::SLOT_W-1:0] s3_slot;
  logic                      s3_fresh, s3_dec, s3_val;
  logic [2*spod_pkg::SQ_W-1:0] s3_pp, s3_qq, s3_ss;

  // stage 4 registers
  logic              v4;
  spod_pkg::result_t s4;
  logic              ov_c;

  assign d      = pairs.data;
  assign en     = !v4 || !q_full;
  assign accept = pairs.valid && pairs.ready;
  assign pairs.ready = en && !clr_busy;

  // rectangle-rectangle with the half-pixel margin on each side
  assign ax_e  = 18'(d.a_x);
  assign ay_e  = 18'(d.a_y);
  assign bx_e  = 18'(d.b_x);
  assign by_e  = 18'(d.b_y);
  assign a_xr  = ax_e + $signed({3'b000, d.a_w}) + ONE;
  assign a_yb  = ay_e + $signed({3'b000, d.a_h}) + ONE;
  assign b_xr  = bx_e + $signed({3'b000, d.b_w}) + ONE;
  assign b_yb  = by_e + $signed({3'b000, d.b_h}) + ONE;
  assign rr_ov = (ax_e <= b_xr) && (a_xr >= bx_e) && (ay_e <= b_yb) && (a_yb >= by_e);

  // rectangle-circle operands in doubled units
  assign rect_a = (d.kind_a == spod_pkg::KIND_RECT);
  assign rx19   = rect_a ? 19'(d.a_x) : 19'(d.b_x);
  assign ry19   = rect_a ? 19'(d.a_y) : 19'(d.b_y);
  assign cx19   = rect_a ? 19'(d.b_x) : 19'(d.a_x);
  assign cy19   = rect_a ? 19'(d.b_y) : 19'(d.a_y);
  assign rw_sel = rect_a ? d.a_w : d.b_w;
  assign rh_sel = rect_a ? d.a_h : d.b_h;
  assign r_sel  = rect_a ? d.b_w : d.a_w;
  assign rw19   = $signed({4'b0000, rw_sel});
  assign rh19   = $signed({4'b0000, rh_sel});

  always_comb begin
    if (d.kind_a == spod_pkg::KIND_RECT && d.kind_b == spod_pkg::KIND_RECT) begin
      test_c = spod_pkg::TEST_RR;
    end else if (d.kind_a == spod_pkg::KIND_CIRCLE && d.kind_b == spod_pkg::KIND_CIRCLE) begin
      test_c = spod_pkg::TEST_CC;
    end else begin
      test_c = spod_pkg::TEST_RC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_slot  <= d.pair_slot;
      s1_fresh <= d.new_pair;
      s1_test  <= test_c;
      s1_rr    <= rr_ov;
      s1_dx    <= 17'(d.a_x) - 17'(d.b_x);
      s1_dy    <= 17'(d.a_y) - 17'(d.b_y);
      s1_rs    <= 16'(d.a_w) + 16'(d.b_w);
      s1_ddx   <= (cx19 <<< 1) - (rx19 <<< 1) - rw19;
      s1_ddy   <= (cy19 <<< 1) - (ry19 <<< 1) - rh19;
      s1_rw    <= rw_sel;
      s1_rh    <= rh_sel;
      s1_r2    <= {r_sel, 1'b0};
    end
  end

  // stage 2: magnitudes, early decisions, square operands
  assign abs_dx  = s1_dx[16] ? -s1_dx : s1_dx;
  assign abs_dy  = s1_dy[16] ? -s1_dy : s1_dy;
  assign abs_ddx = s1_ddx[18] ? -s1_ddx : s1_ddx;
  assign abs_ddy = s1_ddy[18] ? -s1_ddy : s1_ddy;
  assign adx     = abs_ddx[17:0];
  assign ady     = abs_ddy[17:0];
  assign lim_x   = 17'(s1_rw) + 17'(s1_r2);
  assign lim_y   = 17'(s1_rh) + 17'(s1_r2);
  assign far     = (adx > 18'(lim_x)) || (ady > 18'(lim_y));
  assign near    = (adx <= 18'(s1_rw)) || (ady <= 18'(s1_rh));
  assign ex      = spod_pkg::SQ_W'(adx - 18'(s1_rw));
  assign ey      = spod_pkg::SQ_W'(ady - 18'(s1_rh));

  always_comb begin
    dec_c = 1'b1;
    val_c = 1'b0;
    p_c   = '0;
    q_c   = '0;
    s_c   = '0;
    unique case (s1_test)
      spod_pkg::TEST_RR: begin
        val_c = s1_rr;
      end
      spod_pkg::TEST_CC: begin
        dec_c = 1'b0;
        p_c   = abs_dx[15:0];
        q_c   = abs_dy[15:0];
        s_c   = s1_rs;
      end
      spod_pkg::TEST_RC: begin
        dec_c = far || near;
        val_c = !far;
        p_c   = ex;
        q_c   = ey;
        s_c   = s1_r2;
      end
      default: begin
        dec_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_slot  <= s1_slot;
      s2_fresh <= s1_fresh;
      s2_dec   <= dec_c;
      s2_val   <= val_c;
      s2_p     <= p_c;
      s2_q     <= q_c;
      s2_s     <= s_c;
      s3_slot  <= s2_slot;
      s3_fresh <= s2_fresh;
      s3_dec   <= s2_dec;
      s3_val   <= s2_val;
      s3_pp    <= s2_p * s2_p;
      s3_qq    <= s2_q * s2_q;
      s3_ss    <= s2_s * s2_s;
      s4.slot  <= s3_slot;
      s4.fresh <= s3_fresh;
      s4.ov    <= ov_c;
    end
  end

  assign ov_c = s3_dec ? s3_val :
                ((33'(s3_pp) + 33'(s3_qq)) <= 33'(s3_ss));

  assign q_push = v4 && !q_full;
  assign q_data = s4;

endmodule

// ===== hw/rtl/spod_queue.sv =====
// Short queue of decided results between front and back.
module spod_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spod_pkg::result_t push_data,
  output logic              full,
  input  logic              pop,
  output spod_pkg::result_t pop_data,
  output logic              empty
);

  localparam int DEPTH = spod_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  spod_pkg::result_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/spod_back.sv =====
// Back end: per-slot colliding flags, edge detect and result register.
module spod_back #(
  parameter int PAIR_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  spod_pkg::result_t q_data,
  output logic              q_pop,
  output logic              clr_busy,
  spod_result_if.source     results
);

  localparam int AW    = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int EXT_W = spod_pkg::SLOT_W + AW;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic              v1;
  spod_pkg::result_t s1;
  logic              byp, byp_val;
  logic              s1_move;
  logic [EXT_W-1:0]  s1_ext, q_ext;
  logic              s1_in_range;
  logic              prev;

  logic          we, wdata, rdata;
  logic [AW-1:0] waddr, raddr;

  logic                  out_valid;
  spod_pkg::out_item_t   out_data;

  assign clr_busy    = clearing;
  assign s1_ext      = EXT_W'(s1.slot);
  assign q_ext       = EXT_W'(q_data.slot);
  assign s1_in_range = (s1_ext < EXT_W'(PAIR_SLOTS));
  assign s1_move     = v1 && (!out_valid || results.ready);
  assign q_pop       = !q_empty && !clearing && (!v1 || s1_move);

  assign prev  = s1_in_range && !s1.fresh && (byp ? byp_val : rdata);
  assign we    = clearing || (s1_move && s1_in_range);
  assign waddr = clearing ? clr_addr : s1_ext[AW-1:0];
  assign wdata = clearing ? 1'b0 : s1.ov;
  assign raddr = q_ext[AW-1:0];

  spod_ram #(
    .WIDTH (1),
    .DEPTH (PAIR_SLOTS)
  ) u_flags (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (q_pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sweep the flag memory to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(PAIR_SLOTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (q_pop) begin
      v1 <= 1'b1;
    end else if (s1_move) begin
      v1 <= 1'b0;
    end
  end

  // forward the flag written in the same cycle the read was issued
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1      <= q_data;
      byp     <= s1_move && s1_in_range && (s1.slot == q_data.slot);
      byp_val <= s1.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.slot_out          <= s1.slot;
      out_data.overlapping       <= s1.ov;
      out_data.collision_started <= s1.ov && !prev;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  a_started_overlaps: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.collision_started |-> results.data.overlapping)
    else $error("collision_started without overlapping");

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop && !v1)
    else $error("item taken during flag clearing");

  a_bypass_held: assert property (@(posedge clk) disable iff (rst)
    v1 && !s1_move |=> v1 && $stable(s1) && $stable(byp))
    else $error("stalled flag stage lost its item");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    s1_move |-> !clearing)
    else $error("flag write collides with clearing");

endmodule

// ===== hw/rtl/shape_pair_overlap_detector.sv =====
// Top level of the shape pair overlap detector.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------------
//   pairs    | in  | valid / ready | pair_slot, new_pair, two shapes (kind,x,y,w,h)
//   results  | out | valid / ready | slot_out, overlapping, collision_started
//
// One item per cycle unless the flag sweep or a stalled result holds the flow; an item
// passes four front stages, queue, flag read stage and result register to result valid.
// After reset the flag memory is swept to zero; pairs.ready is low during the sweep.
// A stalled result fills the 4-entry queue, then the front holds and pairs.ready drops.
// Flag read-modify-write per item is hidden by forwarding between consecutive items.
module shape_pair_overlap_detector #(
  parameter int PAIR_SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  spod_pair_if.sink     pairs,
  spod_result_if.source results
);

  logic              clr_busy;
  logic              q_push, q_full, q_pop, q_empty;
  spod_pkg::result_t push_data, pop_data;

  spod_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pairs    (pairs),
    .clr_busy (clr_busy),
    .q_push   (q_push),
    .q_data   (push_data),
    .q_full   (q_full)
  );

  spod_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  spod_back #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .q_pop    (q_pop),
    .clr_busy (clr_busy),
    .results  (results)
  );

endmodule
